/* rtl/core/sha224_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// sha224_pkg
// Shared constants, types and helper functions for the SHA-224 hex engine.
// ============================================================================

package sha224_pkg;

    localparam int ROUNDS       = 64;
    localparam int BLOCK_WORDS  = 16;
    localparam int CHAIN_WORDS  = 8;
    localparam int DIGEST_WORDS = 7;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [2:0] MAX_BYTES  = 3'd4;
    localparam logic [2:0] LAST_INDEX = 3'(DIGEST_WORDS - 1);

    typedef logic [CHAIN_WORDS-1:0][31:0] chain_t;
    typedef logic [BLOCK_WORDS-1:0][31:0] block_t;

    typedef struct packed {
        logic start;
        logic restart;
    } rnd_ctl_t;

    localparam chain_t INIT_HASH = {
        32'hbefa4fa4, 32'h64f98fa7, 32'h68581511, 32'hffc00b31,
        32'hf70e5939, 32'h3070dd17, 32'h367cd507, 32'hc1059ed8
    };

    localparam logic [ROUNDS-1:0][31:0] ROUND_K = {
        32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
        32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
        32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
        32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
        32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
        32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
        32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
        32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
        32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
        32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
        32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
        32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
        32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
        32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
        32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
        32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] v);
        big_sig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] v);
        big_sig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] v);
        small_sig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] v);
        small_sig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            hex_char = 8'h30 + {4'h0, nib};
        end else begin
            hex_char = 8'h57 + {4'h0, nib};
        end
    endfunction

endpackage

/* rtl/core/sha224_round.sv */
`timescale 1ns / 1ps
// ============================================================================
// sha224_round
// Iterative SHA-256 compression core: one round per cycle over a sixteen-word
// schedule window, then a fold into the chaining words.
// ============================================================================

module sha224_round (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sha224_pkg::rnd_ctl_t ctl,
    input  sha224_pkg::block_t   blk,
    output sha224_pkg::chain_t   chain,
    output logic                 done
);

    sha224_pkg::chain_t chain_reg;
    sha224_pkg::chain_t v_reg;
    sha224_pkg::block_t w_reg;
    logic [5:0]         cnt_reg;
    logic               busy_reg;
    logic               fin_reg;
    logic               done_reg;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;

    always_comb begin
        t1 = v_reg[7] + sha224_pkg::big_sig1(v_reg[4])
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + sha224_pkg::ROUND_K[cnt_reg] + w_reg[0];
        t2 = sha224_pkg::big_sig0(v_reg[0])
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = w_reg[0] + sha224_pkg::small_sig0(w_reg[1]) + w_reg[9]
                + sha224_pkg::small_sig1(w_reg[14]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= sha224_pkg::INIT_HASH;
            busy_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.restart) begin
                chain_reg <= sha224_pkg::INIT_HASH;
            end
            if (ctl.start) begin
                v_reg    <= chain_reg;
                w_reg    <= blk;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                for (int i = 0; i < sha224_pkg::BLOCK_WORDS - 1; i++) begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[sha224_pkg::BLOCK_WORDS-1] <= w_new;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(sha224_pkg::ROUNDS - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                for (int i = 0; i < sha224_pkg::CHAIN_WORDS; i++) begin
                    chain_reg[i] <= chain_reg[i] + v_reg[i];
                end
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign chain = chain_reg;
    assign done  = done_reg;

endmodule

/* rtl/core/sha224_hex.sv */
`timescale 1ns / 1ps
// ============================================================================
// sha224_hex
// Converts one 32-bit digest word into eight lowercase ASCII hex characters.
// ============================================================================

module sha224_hex (
    input  logic [31:0] word_in,
    output logic [63:0] text_out
);

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            text_out[8*j +: 8] = sha224_pkg::hex_char(word_in[4*j +: 4]);
        end
    end

endmodule

/* rtl/core/sha224_hex_key.sv */
`timescale 1ns / 1ps
// ============================================================================
// sha224_hex_key
// SHA-224 engine: gathers message bytes, pads the final block and emits the
// seven digest words with their hex text.
// ============================================================================
// Each word's valid bytes are packed into the block buffer; every filled block
// passes through a load, 64 rounds of the round unit, a fold and a handback.
// A last word adds the pad mark, zero bytes and 64-bit length (one or two
// blocks); the seven digest words then leave at one per cycle while m_ready
// is high. The input takes one word at a time; it is not ready while busy.
// Reset (synchronous, active low) loads the initial hash and clears the counts.

module sha224_hex_key (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_valid_bytes,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [63:0] m_hex_text,
    output logic [2:0]  m_word_index,
    output logic        m_last_of_digest
);

    typedef enum logic [2:0] {ST_IDLE, ST_WORK, ST_LOAD, ST_COMP, ST_OUT} state_t;
    typedef enum logic [2:0] {PH_DATA, PH_MARK, PH_ZERO, PH_LEN, PH_DONE} phase_t;

    state_t              state_reg;
    phase_t              phase_reg;
    sha224_pkg::block_t  buf_reg;
    logic [5:0]          fill_reg;
    logic [63:0]         bit_len_reg;
    logic [63:0]         len_reg;
    logic [31:0]         data_reg;
    logic [2:0]          rem_reg;
    logic                last_reg;
    logic [2:0]          len_cnt_reg;
    logic [2:0]          out_idx_reg;

    logic [2:0]          count_in;
    logic                push_en;
    logic [7:0]          push_byte;
    sha224_pkg::rnd_ctl_t rnd_ctl;
    sha224_pkg::chain_t   chain;
    logic                 rnd_done;

    assign count_in = (s_valid_bytes > sha224_pkg::MAX_BYTES) ? sha224_pkg::MAX_BYTES
                                                              : s_valid_bytes;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    assign rnd_ctl.start   = (state_reg == ST_LOAD);
    assign rnd_ctl.restart = m_valid && m_ready && (out_idx_reg == sha224_pkg::LAST_INDEX);

    always_comb begin
        push_en   = 1'b0;
        push_byte = 8'h00;
        if (state_reg == ST_WORK) begin
            case (phase_reg)
                PH_DATA: begin
                    push_en   = (rem_reg != 3'd0);
                    push_byte = data_reg[31:24];
                end
                PH_MARK: begin
                    push_en   = 1'b1;
                    push_byte = sha224_pkg::PAD_MARK;
                end
                PH_ZERO: begin
                    push_en = (fill_reg != sha224_pkg::LEN_OFFSET);
                end
                PH_LEN: begin
                    push_en   = 1'b1;
                    push_byte = len_reg[63:56];
                end
                default: begin
                    push_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_DATA;
            fill_reg    <= '0;
            bit_len_reg <= '0;
            rem_reg     <= '0;
            last_reg    <= 1'b0;
            len_cnt_reg <= '0;
            out_idx_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        data_reg    <= s_data_word;
                        rem_reg     <= count_in;
                        last_reg    <= s_last_word;
                        bit_len_reg <= bit_len_reg + 64'({count_in, 3'b000});
                        phase_reg   <= PH_DATA;
                        state_reg   <= ST_WORK;
                    end
                end
                ST_WORK: begin
                    case (phase_reg)
                        PH_DATA: begin
                            if (rem_reg != 3'd0) begin
                                rem_reg  <= rem_reg - 3'd1;
                                data_reg <= {data_reg[23:0], 8'h00};
                            end else if (last_reg) begin
                                phase_reg <= PH_MARK;
                                len_reg   <= bit_len_reg;
                            end else begin
                                state_reg <= ST_IDLE;
                            end
                        end
                        PH_MARK: begin
                            phase_reg <= PH_ZERO;
                        end
                        PH_ZERO: begin
                            if (!push_en) begin
                                phase_reg   <= PH_LEN;
                                len_cnt_reg <= '0;
                            end
                        end
                        PH_LEN: begin
                            len_reg     <= {len_reg[55:0], 8'h00};
                            len_cnt_reg <= len_cnt_reg + 3'd1;
                            if (len_cnt_reg == 3'd7) begin
                                phase_reg <= PH_DONE;
                            end
                        end
                        default: begin
                            state_reg   <= ST_OUT;
                            out_idx_reg <= '0;
                        end
                    endcase
                    if (push_en) begin
                        case (fill_reg[1:0])
                            2'd0:    buf_reg[fill_reg[5:2]][31:24] <= push_byte;
                            2'd1:    buf_reg[fill_reg[5:2]][23:16] <= push_byte;
                            2'd2:    buf_reg[fill_reg[5:2]][15:8]  <= push_byte;
                            default: buf_reg[fill_reg[5:2]][7:0]   <= push_byte;
                        endcase
                        fill_reg <= fill_reg + 6'd1;
                        if (&fill_reg) begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    state_reg <= ST_COMP;
                end
                ST_COMP: begin
                    if (rnd_done) begin
                        state_reg <= ST_WORK;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        if (out_idx_reg == sha224_pkg::LAST_INDEX) begin
                            state_reg   <= ST_IDLE;
                            bit_len_reg <= '0;
                            fill_reg    <= '0;
                        end else begin
                            out_idx_reg <= out_idx_reg + 3'd1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    sha224_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (rnd_ctl),
        .blk     (buf_reg),
        .chain   (chain),
        .done    (rnd_done)
    );

    assign m_digest_word    = chain[out_idx_reg];
    assign m_word_index     = out_idx_reg;
    assign m_last_of_digest = (out_idx_reg == sha224_pkg::LAST_INDEX);

    sha224_hex u_hex (
        .word_in  (m_digest_word),
        .text_out (m_hex_text)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while digest words are pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still ready after a word was taken");

    a_index_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_digest)
            |=> (m_valid && (m_word_index == $past(m_word_index) + 3'd1)))
        else $error("digest word index did not advance by one");

    a_block_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (fill_reg == 6'd0))
        else $error("digest emitted with bytes left in the block buffer");

endmodule
